// ----- rtl/smsra_pkg.sv -----
// ----------------------------------------------------------------------------
// smsra_pkg
// Shared types and constants of the multi-part message reassembly table.
// ----------------------------------------------------------------------------
package smsra_pkg;

   // fixed field widths inside the structs (cover SLOTS <= 16, PARTS <= 16)
   localparam int SlotW   = 4;
   localparam int PartW   = 4;
   localparam int GotW    = 5;
   localparam int MaxOut  = 32;
   localparam int OutCntW = 6;

   localparam logic [31:0] DefaultTimeout = 32'd30000;

   // result kinds
   typedef enum logic [1:0] {
      KIND_SINGLE  = 2'd0,
      KIND_STORED  = 2'd1,
      KIND_MISSING = 2'd2
   } kind_type;

   // search record handed from cell to cell
   typedef struct packed {
      logic             match;
      logic [SlotW-1:0] midx;
      logic             free;
      logic [SlotW-1:0] fidx;
      logic             best;
      logic [SlotW-1:0] bidx;
      logic [31:0]      bborn;
   } rec_type;

   // command broadcast to the cells
   typedef struct packed {
      logic             apply;
      logic             drop;
      logic [SlotW-1:0] slot;
      logic             take;
      logic             store;
      logic [PartW-1:0] pos;
      logic [15:0]      msg_ref;
      logic [63:0]      origin;
      logic [7:0]       count;
      logic [31:0]      born;
      logic [15:0]      stamp;
   } cmd_type;

   // status of one cell
   typedef struct packed {
      logic            busy;
      logic            expired;
      logic [7:0]      count;
      logic [GotW-1:0] got;
      logic [63:0]     origin;
      logic [15:0]     stamp;
   } stat_type;

endpackage

// ----- rtl/smsra_if.sv -----
// ----------------------------------------------------------------------------
// smsra_if
// Valid/ready channels for fragment requests and emitted result transactions.
// ----------------------------------------------------------------------------
interface smsra_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] msg_reference;
   logic [7:0]  fragment_seq;
   logic [7:0]  fragment_count;
   logic [63:0] sender_key;
   logic [15:0] text_handle;
   logic [15:0] stamp_handle;

   modport source (output valid, action, msg_reference, fragment_seq, fragment_count,
                   sender_key, text_handle, stamp_handle, input ready);
   modport sink   (input valid, action, msg_reference, fragment_seq, fragment_count,
                   sender_key, text_handle, stamp_handle, output ready);
endinterface

interface smsra_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [1:0]  slot_index;
   logic [2:0]  piece_index;
   logic [15:0] piece_handle;
   logic [63:0] origin_key;
   logic [15:0] stamp_out;
   logic        message_end;
   logic        last;

   modport source (output valid, event_kind, slot_index, piece_index, piece_handle,
                   origin_key, stamp_out, message_end, last, input ready);
   modport sink   (input valid, event_kind, slot_index, piece_index, piece_handle,
                   origin_key, stamp_out, message_end, last, output ready);
endinterface

// ----- rtl/smsra_ram.sv -----
// ----------------------------------------------------------------------------
// smsra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smsra_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/smsra_cell.sv -----
// ----------------------------------------------------------------------------
// smsra_cell
// One table slot: holds its key and part bookkeeping, updates the search
// record passed along the chain, and flags its own timeout.
// ----------------------------------------------------------------------------
module smsra_cell #(
   parameter int PARTS = 8,
   parameter int IDX   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  smsra_pkg::rec_type rec_in,
   output smsra_pkg::rec_type rec_out,
   input  smsra_pkg::cmd_type cmd,
   input  logic [31:0]        clock_now,
   input  logic [31:0]        timeout,
   input  logic [15:0]        key_ref,
   input  logic [63:0]        key_origin,
   output smsra_pkg::stat_type stat,
   output logic [PARTS-1:0]   present
);
   import smsra_pkg::*;

   localparam int PB = $clog2(PARTS);

   logic             busy_ff, busy_in;
   logic [15:0]      ref_ff, ref_in;
   logic [63:0]      origin_ff, origin_in;
   logic [7:0]       count_ff, count_in;
   logic [GotW-1:0]  got_ff, got_in;
   logic [31:0]      born_ff, born_in;
   logic [15:0]      stamp_ff, stamp_in;
   logic [PARTS-1:0] present_ff, present_in;
   rec_type          rec_ff, rec_next_in;
   logic             sel;

   assign sel = (cmd.slot == SlotW'(IDX));

   // slot update: take, store, release
   always_comb begin
      busy_in    = busy_ff;
      ref_in     = ref_ff;
      origin_in  = origin_ff;
      count_in   = count_ff;
      got_in     = got_ff;
      born_in    = born_ff;
      stamp_in   = stamp_ff;
      present_in = present_ff;
      if (cmd.apply && sel) begin
         if (cmd.take) begin
            busy_in    = 1'b1;
            ref_in     = cmd.msg_ref;
            origin_in  = cmd.origin;
            count_in   = cmd.count;
            born_in    = cmd.born;
            got_in     = '0;
            stamp_in   = '0;
            present_in = '0;
         end
         if (cmd.store) begin
            present_in[cmd.pos[PB-1:0]] = 1'b1;
            if (got_in == '0) begin
               stamp_in = cmd.stamp;
            end
            got_in = got_in + GotW'(1);
         end
      end
      if (cmd.drop && sel) begin
         busy_in    = 1'b0;
         got_in     = '0;
         stamp_in   = '0;
         present_in = '0;
      end
   end

   // search record: first match, first free, oldest
   always_comb begin
      rec_next_in = rec_in;
      if (!rec_in.match && busy_ff && ref_ff == key_ref && origin_ff == key_origin) begin
         rec_next_in.match = 1'b1;
         rec_next_in.midx  = SlotW'(IDX);
      end
      if (!rec_in.free && !busy_ff) begin
         rec_next_in.free = 1'b1;
         rec_next_in.fidx = SlotW'(IDX);
      end
      if (!rec_in.best || born_ff < rec_in.bborn) begin
         rec_next_in.best  = 1'b1;
         rec_next_in.bidx  = SlotW'(IDX);
         rec_next_in.bborn = born_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         got_ff     <= '0;
         born_ff    <= '0;
         stamp_ff   <= '0;
         present_ff <= '0;
         rec_ff     <= '0;
      end else begin
         busy_ff    <= busy_in;
         got_ff     <= got_in;
         born_ff    <= born_in;
         stamp_ff   <= stamp_in;
         present_ff <= present_in;
         rec_ff     <= rec_next_in;
      end
      ref_ff    <= ref_in;
      origin_ff <= origin_in;
      count_ff  <= count_in;
   end

   assign rec_out      = rec_ff;
   assign present      = present_ff;
   assign stat.busy    = busy_ff;
   assign stat.expired = busy_ff && ((clock_now - born_ff) >= timeout);
   assign stat.count   = count_ff;
   assign stat.got     = got_ff;
   assign stat.origin  = origin_ff;
   assign stat.stamp   = stamp_ff;
endmodule

// ----- rtl/sms_fragment_reassembly_table_unit.sv -----
// ----------------------------------------------------------------------------
// sms_fragment_reassembly_table_unit
// Multi-part message reassembly over a chain of slot cells.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time. A single (unconcatenated)
// fragment is emitted directly as one result. A multi-part fragment walks
// its search record through the chain of SLOTS cells, one cell per cycle,
// then updates the chosen slot (ST_APPLY) and tests completion (ST_CHECK).
// A tick advances the time count, latches the expired slots and scans them.
// Each emitted part passes a part store read (ST_RD) and the result register
// (ST_WR), which waits while rsp is stalled; each emitted slot is then freed
// (ST_FREE). At most 32 result transactions are produced per request; any
// further parts of expiring slots are dropped, but those slots are still freed.
// ----------------------------------------------------------------------------
module sms_fragment_reassembly_table_unit #(
   parameter int SLOTS = 4,
   parameter int PARTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   smsra_req_if.sink    req_chan,
   smsra_rsp_if.source  rsp_chan,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);
   import smsra_pkg::*;

   localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PB = $clog2(PARTS);
   localparam int AW = SB + PB;
   localparam int Depth = 1 << AW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SINGLE, ST_SEARCH, ST_APPLY, ST_CHECK,
      ST_TICK, ST_LATCH, ST_SCAN, ST_RD, ST_WR, ST_FREE
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        timeout_ff, timeout_in;
   logic [31:0]        clock_now_ff, clock_now_in;
   logic [15:0]        kref_ff, kref_in;
   logic [63:0]        korigin_ff, korigin_in;
   logic [7:0]         seq_ff, seq_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic [15:0]        text_ff, text_in;
   logic [15:0]        stamp_ff, stamp_in;
   logic [SB-1:0]      srch_ff, srch_in;
   logic [SB-1:0]      cur_slot_ff, cur_slot_in;
   logic [PB-1:0]      piece_ff, piece_in;
   logic [OutCntW-1:0] nout_ff, nout_in;
   logic [SLOTS-1:0]   exp_ff, exp_in;
   logic               tick_mode_ff, tick_mode_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [1:0]         rsp_slot_ff, rsp_slot_in;
   logic [2:0]         rsp_piece_ff, rsp_piece_in;
   logic [15:0]        rsp_handle_ff, rsp_handle_in;
   logic [63:0]        rsp_origin_ff, rsp_origin_in;
   logic [15:0]        rsp_stamp_ff, rsp_stamp_in;
   logic               rsp_end_ff, rsp_end_in;
   logic               rsp_last_ff, rsp_last_in;

   rec_type            chain [SLOTS+1];
   stat_type           stat [SLOTS];
   logic [PARTS-1:0]   present [SLOTS];
   logic [SLOTS-1:0]   expv;
   cmd_type            cmd;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [15:0]        ram_rdata;

   logic               space, out_we, more, endp, have;
   logic [7:0]         lim, pos;
   logic [SB-1:0]      chosen;
   logic               take, store;
   logic [PARTS-1:0]   present_eff;

   // chain of slot cells
   assign chain[0] = '0;
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      smsra_cell #(.PARTS(PARTS), .IDX(g)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .rec_in     (chain[g]),
         .rec_out    (chain[g+1]),
         .cmd        (cmd),
         .clock_now  (clock_now_ff),
         .timeout    (timeout_ff),
         .key_ref    (kref_ff),
         .key_origin (korigin_ff),
         .stat       (stat[g]),
         .present    (present[g])
      );
      assign expv[g] = stat[g].expired;
   end

   // part text store
   smsra_ram #(.WIDTH(16), .DEPTH(Depth)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (text_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // slot choice from the end of the chain
   assign chosen = chain[SLOTS].match ? chain[SLOTS].midx[SB-1:0] :
                   chain[SLOTS].free  ? chain[SLOTS].fidx[SB-1:0] :
                                        chain[SLOTS].bidx[SB-1:0];
   assign take        = !chain[SLOTS].match;
   assign pos         = seq_ff - 8'd1;
   assign present_eff = take ? '0 : present[chosen];
   assign store       = (pos < 8'(PARTS)) && !present_eff[pos[PB-1:0]];

   // emission helpers
   assign lim  = (stat[cur_slot_ff].count > 8'(PARTS)) ? 8'(PARTS) : stat[cur_slot_ff].count;
   assign endp = (8'(piece_ff) == lim - 8'd1);
   assign have = present[cur_slot_ff][piece_ff];
   assign ram_raddr = {cur_slot_ff, piece_ff};

   always_comb begin
      more = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (SB'(j) > cur_slot_ff && exp_ff[j]) begin
            more = 1'b1;
         end
      end
   end

   assign space = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      timeout_in    = csr_we ? csr_wdata : timeout_ff;
      clock_now_in  = clock_now_ff;
      kref_in       = kref_ff;
      korigin_in    = korigin_ff;
      seq_in        = seq_ff;
      cnt_in        = cnt_ff;
      text_in       = text_ff;
      stamp_in      = stamp_ff;
      srch_in       = srch_ff;
      cur_slot_in   = cur_slot_ff;
      piece_in      = piece_ff;
      nout_in       = nout_ff;
      exp_in        = exp_ff;
      tick_mode_in  = tick_mode_ff;
      out_we        = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_piece_in  = rsp_piece_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_origin_in = rsp_origin_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_last_in   = rsp_last_ff;
      cmd           = '0;
      ram_we        = 1'b0;
      ram_waddr     = {chosen, pos[PB-1:0]};
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               kref_in    = req_chan.msg_reference;
               korigin_in = req_chan.sender_key;
               seq_in     = req_chan.fragment_seq;
               cnt_in     = req_chan.fragment_count;
               text_in    = req_chan.text_handle;
               stamp_in   = req_chan.stamp_handle;
               nout_in    = '0;
               srch_in    = '0;
               if (req_chan.action) begin
                  tick_mode_in = 1'b1;
                  state_in     = ST_TICK;
               end else if (req_chan.fragment_count > 8'd1 && req_chan.fragment_seq != 8'd0) begin
                  tick_mode_in = 1'b0;
                  state_in     = ST_SEARCH;
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_SINGLE: begin
            if (space) begin
               out_we        = 1'b1;
               rsp_kind_in   = KIND_SINGLE;
               rsp_slot_in   = '0;
               rsp_piece_in  = '0;
               rsp_handle_in = text_ff;
               rsp_origin_in = korigin_ff;
               rsp_stamp_in  = stamp_ff;
               rsp_end_in    = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (srch_ff == SB'(SLOTS - 1)) begin
               state_in = ST_APPLY;
            end else begin
               srch_in = srch_ff + SB'(1);
            end
         end
         ST_APPLY: begin
            cmd.apply   = 1'b1;
            cmd.slot    = SlotW'(chosen);
            cmd.take    = take;
            cmd.store   = store;
            cmd.pos     = PartW'(pos[PB-1:0]);
            cmd.msg_ref = kref_ff;
            cmd.origin  = korigin_ff;
            cmd.count   = cnt_ff;
            cmd.born    = clock_now_ff;
            cmd.stamp   = stamp_ff;
            ram_we      = store;
            cur_slot_in = chosen;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (8'(stat[cur_slot_ff].got) >= cnt_ff) begin
               piece_in = '0;
               state_in = ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            clock_now_in = clock_now_ff + 32'd1;
            state_in     = ST_LATCH;
         end
         ST_LATCH: begin
            exp_in      = expv;
            cur_slot_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (exp_ff[cur_slot_ff]) begin
               piece_in = '0;
               state_in = ST_RD;
            end else if (cur_slot_ff == SB'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cur_slot_in = cur_slot_ff + SB'(1);
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (nout_ff < OutCntW'(MaxOut)) begin
               if (space) begin
                  out_we        = 1'b1;
                  nout_in       = nout_ff + OutCntW'(1);
                  rsp_kind_in   = have ? KIND_STORED : KIND_MISSING;
                  rsp_slot_in   = 2'(cur_slot_ff);
                  rsp_piece_in  = 3'(piece_ff);
                  rsp_handle_in = have ? ram_rdata : 16'd0;
                  rsp_origin_in = stat[cur_slot_ff].origin;
                  rsp_stamp_in  = stat[cur_slot_ff].stamp;
                  rsp_end_in    = endp;
                  rsp_last_in   = (nout_ff == OutCntW'(MaxOut - 1)) ||
                                  (endp && !(tick_mode_ff && more));
                  state_in      = endp ? ST_FREE : ST_RD;
                  piece_in      = endp ? piece_ff : piece_ff + PB'(1);
               end
            end else begin
               state_in = endp ? ST_FREE : ST_RD;
               piece_in = endp ? piece_ff : piece_ff + PB'(1);
            end
         end
         ST_FREE: begin
            cmd.drop = 1'b1;
            cmd.slot = SlotW'(cur_slot_ff);
            if (tick_mode_ff && cur_slot_ff != SB'(SLOTS - 1)) begin
               cur_slot_in = cur_slot_ff + SB'(1);
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result register: load on write, clear on take
      if (out_we) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= DefaultTimeout;
         clock_now_ff <= '0;
         srch_ff      <= '0;
         cur_slot_ff  <= '0;
         piece_ff     <= '0;
         nout_ff      <= '0;
         exp_ff       <= '0;
         tick_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         clock_now_ff <= clock_now_in;
         srch_ff      <= srch_in;
         cur_slot_ff  <= cur_slot_in;
         piece_ff     <= piece_in;
         nout_ff      <= nout_in;
         exp_ff       <= exp_in;
         tick_mode_ff <= tick_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kref_ff       <= kref_in;
      korigin_ff    <= korigin_in;
      seq_ff        <= seq_in;
      cnt_ff        <= cnt_in;
      text_ff       <= text_in;
      stamp_ff      <= stamp_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_piece_ff  <= rsp_piece_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_origin_ff <= rsp_origin_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_kind   = rsp_kind_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;
   assign rsp_chan.piece_index  = rsp_piece_ff;
   assign rsp_chan.piece_handle = rsp_handle_ff;
   assign rsp_chan.origin_key   = rsp_origin_ff;
   assign rsp_chan.stamp_out    = rsp_stamp_ff;
   assign rsp_chan.message_end  = rsp_end_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // result count per request never passes the cap
   a_nout_cap: assert property (@(posedge clock) disable iff (reset)
      nout_ff <= OutCntW'(MaxOut))
      else $error("result count above cap");

   // the slot just taken or matched is busy
   a_apply_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |=> stat[cur_slot_ff].busy)
      else $error("applied slot not busy");

   // an emitted slot is released
   a_free_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE) |=> !stat[$past(cur_slot_ff)].busy)
      else $error("emitted slot still busy");
endmodule
